// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

  localparam int unsigned SKT_CAPACITY   = 64;
  localparam int unsigned SKT_KEY_BITS   = 32;
  localparam int unsigned SKT_VALUE_BITS = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef logic [FUNC_W-1:0]      func_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [COUNT_W-1:0]     count_t;

  localparam func_t FN_INSERT      = 3'd0;
  localparam func_t FN_FIND        = 3'd1;
  localparam func_t FN_REMOVE      = 3'd2;
  localparam func_t FN_REMOVE_LAST = 3'd3;
  localparam func_t FN_READ_AT     = 3'd4;
  localparam func_t FN_SET_KEY_AT  = 3'd5;

  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NO_MATCH = 2'd2;

endpackage

// ===== hw/rtl/skt_req_if.sv =====
interface skt_req_if;
  logic                  valid;
  logic                  ready;
  skt_pkg::func_t        func;
  skt_pkg::key_t         key;
  skt_pkg::value_t       value;
  skt_pkg::index_t       index;

  modport source (output valid, func, key, value, index, input ready);
  modport sink   (input valid, func, key, value, index, output ready);
endinterface

// ===== hw/rtl/skt_rsp_if.sv =====
interface skt_rsp_if;
  logic                  valid;
  logic                  ready;
  skt_pkg::status_t      status;
  skt_pkg::value_t       value_out;
  skt_pkg::count_t       entry_count;

  modport source (output valid, status, value_out, entry_count, input ready);
  modport sink   (input valid, status, value_out, entry_count, output ready);
endinterface

// ===== hw/rtl/sorted_key_table.sv =====
// Sorted key table: (key, value) entries held in ascending signed key order in two
// single-port-read, single-port-write RAMs (key and value, registered read data).
// One request is processed at a time. find is a linear search, one entry per cycle;
// insert moves each entry above the insert position up by one, remove moves each
// entry above the removed one down by one. Index operations and remove_last read or
// write a single entry. The next request is taken as soon as the result is in the
// output register. Every request gives exactly one response.
module sorted_key_table #(
  parameter int unsigned CAPACITY   = skt_pkg::SKT_CAPACITY,
  parameter int unsigned KEY_BITS   = skt_pkg::SKT_KEY_BITS,
  parameter int unsigned VALUE_BITS = skt_pkg::SKT_VALUE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);
  import skt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_UPRD = 4'd3;
  localparam logic [3:0] S_UPWR = 4'd4;
  localparam logic [3:0] S_DNRD = 4'd5;
  localparam logic [3:0] S_DNWR = 4'd6;
  localparam logic [3:0] S_TAKE = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         ptr_inc, ptr_dec, count_dec;
  func_t                 rq_func_q;
  logic [KEY_BITS-1:0]   rq_key_q;
  logic [VALUE_BITS-1:0] rq_val_q;
  index_t                rq_idx_q;
  status_t               res_st_q, res_st_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;

  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic                  we_key, we_val;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;

  logic                  ovalid_q;
  status_t               ostatus_q;
  value_t                ovalue_q;
  count_t                ocount_q;

  logic                  accept, out_free, greater, key_eq, idx_ok, full;

  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !ovalid_q || rsp_o.ready;
  assign ptr_inc   = ptr_q + CW'(1);
  assign ptr_dec   = ptr_q - CW'(1);
  assign count_dec = count_q - CW'(1);
  assign greater   = $signed(rq_key_q) > $signed(rd_key_q);
  assign key_eq    = rq_key_q == rd_key_q;
  assign idx_ok    = IW'(rq_idx_q) < IW'(count_q);
  assign full      = count_q == CW'(CAPACITY);

  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.status      = ostatus_q;
  assign rsp_o.value_out   = ovalue_q;
  assign rsp_o.entry_count = ocount_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    raddr     = ptr_q[AW-1:0];
    waddr     = ptr_q[AW-1:0];
    we_key    = 1'b0;
    we_val    = 1'b0;
    wkey      = rd_key_q;
    wval      = rd_val_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_st_d  = ST_NO_MATCH;
        res_val_d = '0;
        ptr_d     = '0;
        state_d   = S_FIN;
        unique case (rq_func_q)
          FN_INSERT, FN_FIND, FN_REMOVE: begin
            if (rq_func_q == FN_INSERT && full) begin
              res_st_d = ST_FULL;
            end else if (count_q != '0) begin
              raddr   = '0;
              state_d = S_SCMP;
            end else if (rq_func_q == FN_INSERT) begin
              pos_d   = '0;
              state_d = S_UPRD;
            end
          end
          FN_REMOVE_LAST: begin
            if (count_q != '0) begin
              raddr   = count_dec[AW-1:0];
              count_d = count_dec;
              state_d = S_TAKE;
            end
          end
          FN_READ_AT: begin
            if (idx_ok) begin
              raddr   = AW'(rq_idx_q);
              state_d = S_TAKE;
            end
          end
          FN_SET_KEY_AT: begin
            if (idx_ok) begin
              waddr    = AW'(rq_idx_q);
              wkey     = rq_key_q;
              we_key   = 1'b1;
              res_st_d = ST_DONE;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCMP: begin
        if (greater) begin
          if (ptr_inc == count_q) begin
            if (rq_func_q == FN_INSERT) begin
              pos_d   = count_q;
              ptr_d   = count_q;
              state_d = S_UPRD;
            end else begin
              state_d = S_FIN;
            end
          end else begin
            raddr = ptr_inc[AW-1:0];
            ptr_d = ptr_inc;
          end
        end else if (rq_func_q == FN_INSERT) begin
          pos_d   = ptr_q;
          ptr_d   = count_q;
          state_d = S_UPRD;
        end else if (key_eq) begin
          res_st_d  = ST_DONE;
          res_val_d = rd_val_q;
          state_d   = (rq_func_q == FN_REMOVE) ? S_DNRD : S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UPRD: begin
        if (ptr_q == pos_q) begin
          waddr     = pos_q[AW-1:0];
          wkey      = rq_key_q;
          wval      = rq_val_q;
          we_key    = 1'b1;
          we_val    = 1'b1;
          count_d   = count_q + CW'(1);
          res_st_d  = ST_DONE;
          res_val_d = '0;
          state_d   = S_FIN;
        end else begin
          raddr   = ptr_dec[AW-1:0];
          state_d = S_UPWR;
        end
      end
      S_UPWR: begin
        we_key  = 1'b1;
        we_val  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_UPRD;
      end
      S_DNRD: begin
        if (ptr_inc == count_q) begin
          count_d = count_dec;
          state_d = S_FIN;
        end else begin
          raddr   = ptr_inc[AW-1:0];
          state_d = S_DNWR;
        end
      end
      S_DNWR: begin
        we_key  = 1'b1;
        we_val  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_DNRD;
      end
      S_TAKE: begin
        res_st_d  = ST_DONE;
        res_val_d = rd_val_q;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_key) begin
      key_mem[waddr] <= wkey;
    end
    if (we_val) begin
      val_mem[waddr] <= wval;
    end
    rd_key_q <= key_mem[raddr];
    rd_val_q <= val_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rq_func_q <= req_i.func;
      rq_key_q  <= KEY_BITS'(req_i.key);
      rq_val_q  <= VALUE_BITS'(req_i.value);
      rq_idx_q  <= req_i.index;
    end
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    ptr_q     <= ptr_d;
    pos_q     <= pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_FIN && out_free) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      ostatus_q <= res_st_q;
      ovalue_q  <= (res_st_q == ST_DONE) ? VALUE_W'(res_val_q) : '0;
      ocount_q  <= COUNT_W'(count_q);
    end
  end

endmodule

// ===== hw/rtl/skt_checker.sv =====
module skt_checker #(
  parameter int unsigned CAPACITY = skt_pkg::SKT_CAPACITY
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input skt_pkg::status_t rsp_status_i,
  input skt_pkg::value_t  rsp_value_i,
  input skt_pkg::count_t  rsp_count_i
);
  import skt_pkg::*;

  // one request in flight: no transfer straight after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one still in progress");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_DONE |-> rsp_value_i == '0)
    else $error("nonzero value on failed request");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |-> rsp_count_i == COUNT_W'(CAPACITY))
    else $error("table full reported with spare capacity");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_value_i) && $stable(rsp_count_i))
    else $error("stalled response changed");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_value_i  (rsp_o.value_out),
  .rsp_count_i  (rsp_o.entry_count)
);
